/* rtl/core/spq_pkg.sv */
// Shared types, sizes and codes for the sorted-insert priority queue.
// No dependencies; imported by every module of the block.
package spq_pkg;

    localparam int DEPTH     = 16;
    localparam int TAG_BITS  = 32;
    localparam int PRI_BITS  = 16;
    localparam int OCC_BITS  = 5;
    localparam int KIND_BITS = 2;
    localparam int STAT_BITS = 2;
    localparam int CNT_BITS  = $clog2(DEPTH + 1);
    localparam int IDX_BITS  = $clog2(DEPTH);

    // stream payload layout
    localparam int IN_DATA_BITS  = ((TAG_BITS + PRI_BITS + 7) / 8) * 8;
    localparam int OUT_USED_BITS = TAG_BITS + PRI_BITS + OCC_BITS;
    localparam int OUT_DATA_BITS = ((OUT_USED_BITS + 7) / 8) * 8;

    localparam logic [KIND_BITS-1:0] KIND_INSERT  = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_REMOVE  = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_DISPLAY = 2'd2;

    localparam logic [STAT_BITS-1:0] STATUS_OK    = 2'd0;
    localparam logic [STAT_BITS-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STAT_BITS-1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic        [TAG_BITS-1:0] tag;
        logic signed [PRI_BITS-1:0] pri;
    } entry_t;

    typedef struct packed {
        logic insert;
        logic remove;
    } cell_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DISP = 2'b10
    } state_t;

endpackage

/* rtl/core/spq_cell.sv */
// One slot of the sorted cell row: holds an entry, compares it with the
// incoming priority and shifts toward either neighbor. Uses spq_pkg.
module spq_cell (
    input  logic              clk,
    input  spq_pkg::cell_cmd_t cmd,
    input  spq_pkg::entry_t   new_entry,
    input  spq_pkg::entry_t   left_entry,
    input  spq_pkg::entry_t   right_entry,
    input  logic              occupied,
    input  logic              left_occupied,
    input  logic              left_gt,
    output spq_pkg::entry_t   entry,
    output logic              gt
);
    import spq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;
    logic   at_end;

    assign gt     = occupied && ($signed(entry_reg.pri) > $signed(new_entry.pri));
    // first free slot: the new item lands here when nothing stored is larger
    assign at_end = !occupied && left_occupied;
    assign entry  = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.insert)
        begin
            if (left_gt)
            begin
                entry_next = left_entry;
            end
            else if (gt || at_end)
            begin
                entry_next = new_entry;
            end
        end
        else if (cmd.remove)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

/* rtl/core/sorted_insert_priority_queue.sv */
// Sorted-insert priority queue: a row of DEPTH cells kept in ascending
// priority order, cell 0 at the front. Insert, remove and unused kinds each
// give one registered result; an item may follow every cycle while
// results are taken. A display of N stored items gives N results, one per
// cycle from the output register while they are taken, and holds off input
// until the last of them is registered.
// Equal priorities leave in arrival order. Insert on a full queue reports
// full; remove or display on an empty queue reports empty.
// Depends on spq_pkg and spq_cell.
module sorted_insert_priority_queue (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // tag_in [31:0], priority_in [47:32]
    input  logic [spq_pkg::IN_DATA_BITS-1:0]    s_tdata,
    // kind [1:0]
    input  logic [spq_pkg::KIND_BITS-1:0]       s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // tag_out [31:0], priority_out [47:32], occupancy [52:48], zero above
    output logic [spq_pkg::OUT_DATA_BITS-1:0]   m_tdata,
    // status [1:0]
    output logic [spq_pkg::STAT_BITS-1:0]       m_tuser,
    output logic                                m_tlast
);
    import spq_pkg::*;

    state_t                state_reg, state_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic [IDX_BITS-1:0]   idx_reg, idx_next;

    logic                  out_valid_reg, out_valid_next;
    logic [STAT_BITS-1:0]  status_reg, status_next;
    entry_t                res_reg, res_next;
    logic [OCC_BITS-1:0]   occ_reg, occ_next;
    logic                  last_reg, last_next;

    entry_t                new_entry;
    entry_t                cells   [DEPTH];
    logic   [DEPTH-1:0]    gt_vec;
    logic   [DEPTH-1:0]    occ_vec;
    cell_cmd_t             cmd;
    logic                  out_free;
    logic                  accept;
    logic                  full;
    logic                  empty;
    logic                  disp_last;

    assign new_entry.tag = s_tdata[TAG_BITS-1:0];
    assign new_entry.pri = s_tdata[TAG_BITS+PRI_BITS-1:TAG_BITS];

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;
    assign full     = (count_reg == CNT_BITS'(DEPTH));
    assign empty    = (count_reg == '0);
    assign disp_last = ((CNT_BITS'(idx_reg) + CNT_BITS'(1)) == count_reg);

    assign cmd.insert = accept && (s_tuser == KIND_INSERT) && !full;
    assign cmd.remove = accept && (s_tuser == KIND_REMOVE) && !empty;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            assign occ_vec[gi] = (CNT_BITS'(gi) < count_reg);
            if (gi == 0)
            begin : g_front
                spq_cell u_cell (
                    .clk           (clk),
                    .cmd           (cmd),
                    .new_entry     (new_entry),
                    .left_entry    (new_entry),
                    .right_entry   (cells[gi+1]),
                    .occupied      (occ_vec[gi]),
                    .left_occupied (1'b1),
                    .left_gt       (1'b0),
                    .entry         (cells[gi]),
                    .gt            (gt_vec[gi])
                );
            end
            else if (gi == DEPTH - 1)
            begin : g_back
                spq_cell u_cell (
                    .clk           (clk),
                    .cmd           (cmd),
                    .new_entry     (new_entry),
                    .left_entry    (cells[gi-1]),
                    .right_entry   (cells[gi]),
                    .occupied      (occ_vec[gi]),
                    .left_occupied (occ_vec[gi-1]),
                    .left_gt       (gt_vec[gi-1]),
                    .entry         (cells[gi]),
                    .gt            (gt_vec[gi])
                );
            end
            else
            begin : g_mid
                spq_cell u_cell (
                    .clk           (clk),
                    .cmd           (cmd),
                    .new_entry     (new_entry),
                    .left_entry    (cells[gi-1]),
                    .right_entry   (cells[gi+1]),
                    .occupied      (occ_vec[gi]),
                    .left_occupied (occ_vec[gi-1]),
                    .left_gt       (gt_vec[gi-1]),
                    .entry         (cells[gi]),
                    .gt            (gt_vec[gi])
                );
            end
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !m_tready;
        status_next    = status_reg;
        res_next       = res_reg;
        occ_next       = occ_reg;
        last_next      = last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    out_valid_next = 1'b1;
                    status_next    = STATUS_OK;
                    res_next       = '0;
                    last_next      = 1'b1;
                    occ_next       = OCC_BITS'(count_reg);
                    case (s_tuser)
                        KIND_INSERT:
                        begin
                            if (full)
                            begin
                                status_next = STATUS_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + CNT_BITS'(1);
                                occ_next   = OCC_BITS'(count_next);
                            end
                        end
                        KIND_REMOVE:
                        begin
                            if (empty)
                            begin
                                status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                res_next   = cells[0];
                                count_next = count_reg - CNT_BITS'(1);
                                occ_next   = OCC_BITS'(count_next);
                            end
                        end
                        KIND_DISPLAY:
                        begin
                            if (empty)
                            begin
                                status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                // results come from the burst state
                                out_valid_next = out_valid_reg && !m_tready;
                                idx_next       = '0;
                                state_next     = ST_DISP;
                            end
                        end
                        default:
                        begin
                            status_next = STATUS_OK;
                        end
                    endcase
                end
            end
            ST_DISP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = STATUS_OK;
                    res_next       = cells[idx_reg];
                    occ_next       = OCC_BITS'(count_reg);
                    last_next      = disp_last;
                    idx_next       = idx_reg + IDX_BITS'(1);
                    if (disp_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        res_reg    <= res_next;
        occ_reg    <= occ_next;
        last_reg   <= last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = OUT_DATA_BITS'({occ_reg, res_reg.pri, res_reg.tag});

endmodule

/* rtl/core/spq_checker.sv */
// Port-level checks for the sorted-insert priority queue, bound to the top.
// Depends on spq_pkg and sorted_insert_priority_queue.
module spq_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic [spq_pkg::IN_DATA_BITS-1:0]    s_tdata,
    input logic [spq_pkg::KIND_BITS-1:0]       s_tuser,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [spq_pkg::OUT_DATA_BITS-1:0]   m_tdata,
    input logic [spq_pkg::STAT_BITS-1:0]       m_tuser,
    input logic                                m_tlast
);
    import spq_pkg::*;

    localparam int OCC_LO = TAG_BITS + PRI_BITS;

    logic [OCC_BITS-1:0] occ;
    assign occ = m_tdata[OCC_LO+OCC_BITS-1:OCC_LO];

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result changed while stalled");

    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == STATUS_FULL) |-> (occ == OCC_BITS'(DEPTH)) && m_tlast)
        else $error("full status with queue not full");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == STATUS_EMPTY) |-> (occ == '0) && m_tlast
            && (m_tdata[OCC_LO-1:0] == '0))
        else $error("empty status with stored items or payload");

    // only a display burst gives results without last, and those are ok
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> (m_tuser == STATUS_OK) && (occ != '0) && !s_tready)
        else $error("burst result malformed or input open mid-burst");

    a_occ: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> occ <= OCC_BITS'(DEPTH))
        else $error("occupancy beyond depth");

endmodule

bind sorted_insert_priority_queue spq_checker u_spq_checker (.*);
